@@ hw/rtl/npcs_pkg.sv @@
`default_nettype none

package npcs_pkg;

    localparam int PALETTE_ENTRIES = 256;

    localparam int IDX_W    = 8;
    localparam int CNT_W    = IDX_W + 1;
    localparam int CHAN_W   = 8;
    localparam int FIELD_W  = 5;
    localparam int CODE_W   = 3 * FIELD_W;
    localparam int SQ_W     = 2 * CHAN_W;
    localparam int DIST_W   = 18;
    localparam int STORE_DEPTH = 2 ** IDX_W;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic              op;
        logic [IDX_W-1:0]  entry_index;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CODE_W-1:0] color_code;
    } t_npcs_req;

    typedef struct packed {
        logic [IDX_W-1:0]  nearest_index;
        logic [DIST_W-1:0] nearest_distance;
    } t_npcs_rsp;

endpackage

`default_nettype wire

@@ hw/rtl/npcs_if.sv @@
`default_nettype none

interface npcs_req_if
    import npcs_pkg::*;
;
    logic      valid;
    logic      ready;
    t_npcs_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface npcs_rsp_if
    import npcs_pkg::*;
;
    logic      valid;
    logic      ready;
    t_npcs_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/nearest_palette_color_search.sv @@
// Channel   Direction  Payload
// i_req     in         op, entry_index, red, green, blue, color_code
// o_rsp     out        nearest_index, nearest_distance (one per query request)
//
// A load request writes one palette entry.
// A query request walks the palette through one shared distance unit, one entry a cycle,
// behind the registered palette read and a registered distance, then keeps the smallest.
// The input is not ready while a query runs; the result waits in an output register.
// Reset is synchronous and active low; it clears control state, not the palette.
`default_nettype none

module nearest_palette_color_search
    import npcs_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    npcs_req_if.sink    i_req,
    npcs_rsp_if.source  o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] NUM_ENT  = CNT_W'(PALETTE_ENTRIES);

    t_state r_state;

    logic [3*CHAN_W-1:0] r_mem [STORE_DEPTH];
    logic [3*CHAN_W-1:0] r_rd_data;

    logic [CNT_W-1:0]  r_addr;
    logic              r_rd_vld;
    logic [IDX_W-1:0]  r_rd_idx;
    logic              r_dist_vld;
    logic [IDX_W-1:0]  r_dist_idx;
    logic [DIST_W-1:0] r_dist;
    logic [IDX_W-1:0]  r_best_idx;
    logic [DIST_W-1:0] r_best_dist;

    logic [CHAN_W-1:0] r_qr;
    logic [CHAN_W-1:0] r_qg;
    logic [CHAN_W-1:0] r_qb;

    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_idx;
    logic [DIST_W-1:0] r_out_dist;

    logic              req_acc;
    logic              wr_en;
    logic              rd_en;
    logic [DIST_W-1:0] n_dist;

    function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
        logic [CHAN_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign wr_en       = req_acc && (i_req.payload.op == OP_LOAD)
                         && ({1'b0, i_req.payload.entry_index} < NUM_ENT);
    assign rd_en       = (r_state == S_SCAN) && (r_addr < NUM_ENT);

    assign n_dist = DIST_W'(sq_diff(r_qr, r_rd_data[3*CHAN_W-1:2*CHAN_W]))
                  + DIST_W'(sq_diff(r_qg, r_rd_data[2*CHAN_W-1:CHAN_W]))
                  + DIST_W'(sq_diff(r_qb, r_rd_data[CHAN_W-1:0]));

    assign o_rsp.valid                    = r_out_valid;
    assign o_rsp.payload.nearest_index    = r_out_idx;
    assign o_rsp.payload.nearest_distance = r_out_dist;

    // Palette store: one write port for loads, one registered read port for the scan.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_req.payload.entry_index] <= {i_req.payload.red,
                                                 i_req.payload.green,
                                                 i_req.payload.blue};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_addr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_dist_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_rsp.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_rd_vld   <= 1'b0;
                    r_dist_vld <= 1'b0;
                    r_addr     <= '0;
                    if (req_acc && (i_req.payload.op == OP_QUERY)) begin
                        r_qr    <= {i_req.payload.color_code[FIELD_W-1:0], 3'b100};
                        r_qg    <= {i_req.payload.color_code[2*FIELD_W-1:FIELD_W], 3'b100};
                        r_qb    <= {i_req.payload.color_code[3*FIELD_W-1:2*FIELD_W], 3'b100};
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rd_vld <= rd_en;
                    if (rd_en) begin
                        r_rd_idx <= r_addr[IDX_W-1:0];
                        r_addr   <= r_addr + CNT_W'(1);
                    end
                    r_dist_vld <= r_rd_vld;
                    if (r_rd_vld) begin
                        r_dist     <= n_dist;
                        r_dist_idx <= r_rd_idx;
                    end
                    if (r_dist_vld) begin
                        if ((r_dist_idx == '0) || (r_dist < r_best_dist)) begin
                            r_best_dist <= r_dist;
                            r_best_idx  <= r_dist_idx;
                        end
                        if (r_dist_idx == LAST_IDX) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= r_best_idx;
                        r_out_dist  <= r_best_dist;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
